// ===== src/spgt_pkg.sv =====
// Package for the scan peak gradient tracker: widths, constants and quotient saturation.
package spgt_pkg;

	localparam int NUM_AXES_DEF = 6;
	localparam int POS_COUNT    = 6;
	localparam int AXIS_W       = 3;
	localparam int DATA_W       = 32;
	localparam int FLAGS_W      = 3;
	localparam int NM_PER_MM    = 1000000;
	localparam int Q_FRAC       = 16;

	// |dv| < 2^32, |dv| * 1e6 < 2^52
	localparam int DVD_W = 52;
	// quotient bits worked out per division; anything wider saturates
	localparam int Q_W   = 33;
	localparam int CNT_W = $clog2(Q_W + 1);

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Signed, saturated result from quotient magnitude, sign and overflow.
	function automatic logic [DATA_W-1:0] sat_quo(input logic [Q_W-1:0] mag,
			input logic neg, input logic ovf);
		logic [Q_W-1:0] lim;
		logic [Q_W-1:0] negd;
		lim  = Q_W'(SAT_MIN);
		negd = ~mag + Q_W'(1);
		if (!neg) begin
			if (ovf || (mag > Q_W'(SAT_MAX))) begin
				return SAT_MAX;
			end
			return mag[DATA_W-1:0];
		end
		if (ovf || (mag > lim)) begin
			return SAT_MIN;
		end
		return negd[DATA_W-1:0];
	endfunction

endpackage

// ===== src/scan_peak_gradient_tracker.sv =====
// Scan peak gradient tracker: peak capture plus gradient and improvement quotients.
// An accepted item passes ST_PREP, the gradient load and division, the improvement load and
// division and ST_FIN; in_stall stays high while an item is in work, so no new item is
// taken until its result is in the output register, and a stalled output register holds
// ST_FIN. The work is two passes (overflow check plus 33 quotient bits) of one shared
// restoring divider, plus the multiply by 1e6 and the load steps.
// Reset (arst_n low): sequencer idle, no output valid, no peak and no previous measurement held.
module scan_peak_gradient_tracker
	import spgt_pkg::*;
#(
	parameter int NUM_AXES = NUM_AXES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic signed [DATA_W-1:0] sample_value,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [DATA_W-1:0] pos_u,
	input  logic signed [DATA_W-1:0] pos_v,
	input  logic signed [DATA_W-1:0] pos_w,
	input  logic        [AXIS_W-1:0] scan_axis,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic       [FLAGS_W-1:0] status_flags,
	output logic signed [DATA_W-1:0] gradient,
	output logic signed [DATA_W-1:0] improvement,
	output logic signed [DATA_W-1:0] peak_value,
	output logic signed [DATA_W-1:0] peak_x,
	output logic signed [DATA_W-1:0] peak_y,
	output logic signed [DATA_W-1:0] peak_z,
	output logic signed [DATA_W-1:0] peak_u,
	output logic signed [DATA_W-1:0] peak_v,
	output logic signed [DATA_W-1:0] peak_w
);

	// Sequencer: take item, update held state, then two divisions on one unit.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,   // differences, flags, peak and previous-measurement update
		ST_GLOAD,  // |dv| * 1e6 into the divider, |dpos| as divisor
		ST_GDIV,   // gradient division
		ST_ILOAD,  // saturate gradient, load |dv| << 16 over previous value
		ST_IDIV,   // improvement division
		ST_FIN     // result into the output register once it is free
	} state_t;

	state_t state_q;

	// Item as taken
	logic                     type_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] pos_q [POS_COUNT];
	logic        [AXIS_W-1:0] axis_q;

	// Tracker state
	logic                     prev_valid_q;
	logic signed [DATA_W-1:0] prev_sample_q;
	logic signed [DATA_W-1:0] prev_pos_q [NUM_AXES];
	logic                     peak_valid_q;
	logic signed [DATA_W-1:0] peak_sample_q;
	logic signed [DATA_W-1:0] peak_pos_q [POS_COUNT];

	// Operands kept across the divisions
	logic [DATA_W-1:0]  dv_mag_q;
	logic               dv_neg_q;
	logic [DATA_W-1:0]  dist_mag_q;
	logic               dist_neg_q;
	logic [DATA_W-1:0]  psmp_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [DATA_W-1:0]  grad_q;

	// Shared divider: partial remainder, dividend/quotient shifter, divisor
	logic [DATA_W-1:0] rem_q;
	logic [Q_W-1:0]    sh_q;
	logic [DATA_W-1:0] dvs_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;

	// Output register
	logic                     out_valid_q;
	logic       [FLAGS_W-1:0] flags_out_q;
	logic signed [DATA_W-1:0] grad_out_q;
	logic signed [DATA_W-1:0] impr_out_q;
	logic signed [DATA_W-1:0] peak_val_out_q;
	logic signed [DATA_W-1:0] peak_pos_out_q [POS_COUNT];

	logic                     in_xfer;
	logic                     out_xfer;
	logic signed [DATA_W-1:0] pos_in [POS_COUNT];

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign pos_in[3] = pos_u;
	assign pos_in[4] = pos_v;
	assign pos_in[5] = pos_w;

	// ---------------------------------------------------------------
	// Item evaluation against the held state (used in ST_PREP)
	// ---------------------------------------------------------------
	logic              is_meas;
	logic [DATA_W:0]   dv;
	logic [DATA_W:0]   dv_abs;
	logic [DATA_W:0]   dpos;
	logic [DATA_W:0]   dist_abs;
	logic              grad_ok;
	logic              impr_ok;
	logic              new_peak;
	logic              load_peak;

	assign is_meas = type_q;
	assign dv      = {val_q[DATA_W-1], val_q} - {prev_sample_q[DATA_W-1], prev_sample_q};
	assign dv_abs  = dv[DATA_W] ? (~dv + (DATA_W+1)'(1)) : dv;

	// Axis outside the stored axes counts as not moved.
	always_comb begin
		dpos = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (axis_q == AXIS_W'(i)) begin
				dpos = {pos_q[i][DATA_W-1], pos_q[i]} -
					{prev_pos_q[i][DATA_W-1], prev_pos_q[i]};
			end
		end
	end

	assign dist_abs  = dpos[DATA_W] ? (~dpos + (DATA_W+1)'(1)) : dpos;
	assign grad_ok   = is_meas && prev_valid_q && (dpos != '0);
	assign impr_ok   = is_meas && prev_valid_q && !prev_sample_q[DATA_W-1] &&
		(prev_sample_q != '0);
	assign new_peak  = is_meas && (!peak_valid_q || (val_q > peak_sample_q));
	assign load_peak = !is_meas || new_peak;

	// ---------------------------------------------------------------
	// Divider loading and the shared compare/subtract step
	// ---------------------------------------------------------------
	logic [DVD_W-1:0] prod;
	logic [DVD_W-1:0] load_dvd;
	logic [DATA_W:0]  trial;
	logic [DATA_W+1:0] diff;
	logic             ge;

	assign prod     = DVD_W'(dv_mag_q) * DVD_W'(NM_PER_MM);
	assign load_dvd = (state_q == ST_GLOAD) ? prod : (DVD_W'(dv_mag_q) << Q_FRAC);

	// Step 0 checks the high dividend part against the divisor (quotient too wide);
	// later steps bring down one dividend bit each.
	assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, sh_q[Q_W-1]};
	assign diff  = {1'b0, trial} - {2'b0, dvs_q};
	assign ge    = !diff[DATA_W+1];

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			type_q <= req_type;
			val_q  <= sample_value;
			axis_q <= scan_axis;
			for (int i = 0; i < POS_COUNT; i++) begin
				pos_q[i] <= pos_in[i];
			end
		end
		unique case (state_q)
			ST_PREP: begin
				dv_mag_q   <= dv_abs[DATA_W-1:0];
				dv_neg_q   <= dv[DATA_W];
				dist_mag_q <= dist_abs[DATA_W-1:0];
				dist_neg_q <= dpos[DATA_W];
				psmp_q     <= prev_sample_q;
				flags_q    <= {new_peak, impr_ok, grad_ok};
				if (load_peak) begin
					peak_sample_q <= val_q;
					for (int i = 0; i < POS_COUNT; i++) begin
						peak_pos_q[i] <= pos_q[i];
					end
				end
				if (is_meas) begin
					prev_sample_q <= val_q;
					for (int i = 0; i < NUM_AXES; i++) begin
						prev_pos_q[i] <= pos_q[i];
					end
				end
			end
			ST_GLOAD, ST_ILOAD: begin
				rem_q <= DATA_W'(load_dvd[DVD_W-1:Q_W]);
				sh_q  <= load_dvd[Q_W-1:0];
				dvs_q <= (state_q == ST_GLOAD) ? dist_mag_q : psmp_q;
				if (state_q == ST_ILOAD) begin
					grad_q <= flags_q[0] ?
						sat_quo(sh_q, dv_neg_q ^ dist_neg_q, ovf_q) : '0;
				end
			end
			ST_GDIV, ST_IDIV: begin
				if (cnt_q == '0) begin
					ovf_q <= ge;
				end else begin
					rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
					sh_q  <= {sh_q[Q_W-2:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, valid flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			prev_valid_q   <= 1'b0;
			peak_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			flags_out_q    <= '0;
			grad_out_q     <= '0;
			impr_out_q     <= '0;
			peak_val_out_q <= '0;
			for (int i = 0; i < POS_COUNT; i++) begin
				peak_pos_out_q[i] <= '0;
			end
		end else begin
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (is_meas) begin
						prev_valid_q <= 1'b1;
					end
					if (load_peak) begin
						peak_valid_q <= 1'b1;
					end
					state_q <= ST_GLOAD;
				end
				ST_GLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_GDIV;
				end
				ST_GDIV: begin
					if (cnt_q == CNT_W'(Q_W)) begin
						state_q <= ST_ILOAD;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_ILOAD: begin
					cnt_q   <= '0;
					state_q <= ST_IDIV;
				end
				ST_IDIV: begin
					if (cnt_q == CNT_W'(Q_W)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FIN: begin
					// wait for the previous result's transfer
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						flags_out_q    <= flags_q;
						grad_out_q     <= grad_q;
						impr_out_q     <= flags_q[1] ? sat_quo(sh_q, dv_neg_q, ovf_q) : '0;
						peak_val_out_q <= peak_valid_q ? peak_sample_q : '0;
						for (int i = 0; i < POS_COUNT; i++) begin
							peak_pos_out_q[i] <= peak_valid_q ? peak_pos_q[i] : '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status_flags = flags_out_q;
	assign gradient     = grad_out_q;
	assign improvement  = impr_out_q;
	assign peak_value   = peak_val_out_q;
	assign peak_x       = peak_pos_out_q[0];
	assign peak_y       = peak_pos_out_q[1];
	assign peak_z       = peak_pos_out_q[2];
	assign peak_u       = peak_pos_out_q[3];
	assign peak_v       = peak_pos_out_q[4];
	assign peak_w       = peak_pos_out_q[5];

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_PREP))
		else $error("accepted item did not start the sequencer");

	a_grad_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_flags[0]) |-> prev_valid_q)
		else $error("gradient flagged without a previous measurement");

	a_grad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_flags[0]) |-> (gradient == '0))
		else $error("gradient nonzero while not valid");

	a_impr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_flags[1]) |-> (improvement == '0))
		else $error("improvement nonzero while not valid");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_GDIV) || (state_q == ST_IDIV)) |-> (cnt_q <= CNT_W'(Q_W)))
		else $error("divider step count out of range");

endmodule
